### design/twcc_pkg.sv
// ----------------------------------------------------------------------------
// twcc_pkg
// Shared types, constants and helpers of the tree walk collision counter.
// ----------------------------------------------------------------------------
package twcc_pkg;

    localparam int MAX_DEPTH = 10;
    localparam int SLOTS     = 1 << MAX_DEPTH;
    localparam int ADDR_W    = MAX_DEPTH;
    localparam int CNT_W     = ADDR_W + 1;       // address counter, reaches SLOTS
    localparam int DEPTH_W   = 4;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int LIDX_W    = $clog2(MAX_DEPTH);
    localparam int FILL_W    = 2;

    localparam int PROBE_W   = 11;
    localparam int COLL_W    = 10;
    localparam int SUCC_W    = 11;
    localparam int IDLE_W    = 11;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TREE_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE  = 1'd1;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd3;

    localparam logic [FILL_W-1:0] FILL_NONE = 2'd0;
    localparam logic [FILL_W-1:0] FILL_ONE  = 2'd1;
    localparam logic [FILL_W-1:0] FILL_MANY = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_LOAD,
        S_READ,
        S_LEAF,
        S_CLIMB,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic clr_wr;
        logic addr_clr;
        logic addr_inc;
        logic leaf_tree;
        logic leaf_scan;
        logic climb;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic init_end;
        logic scan_end;
        logic in_lim;
        logic climb_done;
        logic leaf_mode;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [1:0] probe;
        logic       coll;
        logic [1:0] succ;
        logic       idle;
    } t_inc;

    // Counts added for one probed node of the given fill at the given level.
    function automatic t_inc node_inc(input logic [FILL_W-1:0] fill,
                                      input logic [LVL_W-1:0] lvl);
        t_inc r;
        r = '0;
        if (fill == FILL_NONE) begin
            r.probe = 2'd1;
            r.idle  = 1'b1;
        end else if (fill == FILL_ONE) begin
            r.probe = 2'd1;
            r.succ  = 2'd1;
        end else if (lvl <= LVL_W'(1)) begin
            // A collided pair of leaves resolves in two more slots.
            r.probe = 2'd3;
            r.coll  = 1'b1;
            r.succ  = 2'd2;
        end else begin
            r.probe = 2'd1;
            r.coll  = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [FILL_W-1:0] fill_add(input logic [FILL_W-1:0] a,
                                                   input logic [FILL_W-1:0] b);
        logic [FILL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, FILL_MANY}) ? FILL_MANY : s[FILL_W-1:0];
    endfunction

endpackage

### design/twcc_label_if.sv
// ----------------------------------------------------------------------------
// twcc_label_if
// Label channel: one station label per transfer.
// ----------------------------------------------------------------------------
interface twcc_label_if;
    logic       valid;
    logic       ready;
    logic [9:0] station_label;
    logic       label_valid;
    logic       last_label;

    modport source (output valid, station_label, label_valid, last_label, input ready);
    modport sink   (input valid, station_label, label_valid, last_label, output ready);
endinterface

### design/twcc_result_if.sv
// ----------------------------------------------------------------------------
// twcc_result_if
// Result channel: the four counts of one resolved set per transfer.
// ----------------------------------------------------------------------------
interface twcc_result_if;
    logic        valid;
    logic        ready;
    logic [10:0] probe_count;
    logic [9:0]  collision_count;
    logic [10:0] success_count;
    logic [10:0] idle_count;

    modport source (output valid, probe_count, collision_count, success_count, idle_count,
                    input ready);
    modport sink   (input valid, probe_count, collision_count, success_count, idle_count,
                    output ready);
endinterface

### design/tree_walk_collision_counter_unit.sv
// ----------------------------------------------------------------------------
// tree_walk_collision_counter_unit
// Loads station labels into an occupancy bitmap and, on the last label of a
// set, counts the probes, collisions, successes and idles of its resolution.
// ----------------------------------------------------------------------------
// Labels are taken one per cycle while loading; each valid label inside the
// tree sets a bit of a bitmap RAM with one write port and a registered read.
// The last label of a set starts a scan over the 2^depth slots: each slot is
// read, then used and cleared, and in tree mode each node of the tree is
// closed in turn as it closes on the way up. Slots above the tree that were
// set under a larger depth are swept clear. Labels of the next set are
// accepted as soon as the result sits in the output register. After reset
// all 1024 slots of the bitmap are cleared, during which no label is
// accepted; configuration writes are taken anytime.
// ----------------------------------------------------------------------------
module tree_walk_collision_counter_unit
    import twcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    twcc_label_if.sink            i_label,
    twcc_result_if.source         o_result
);
    t_cmd cmd;
    t_sts sts;

    twcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_label.valid),
        .i_in_last  (i_label.last_label),
        .o_in_ready (i_label.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    twcc_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_station_label   (i_label.station_label),
        .i_label_valid     (i_label.label_valid),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_probe_count     (o_result.probe_count),
        .o_collision_count (o_result.collision_count),
        .o_success_count   (o_result.success_count),
        .o_idle_count      (o_result.idle_count)
    );
endmodule

### design/twcc_ram.sv
// ----------------------------------------------------------------------------
// twcc_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module twcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/twcc_ctrl.sv
// ----------------------------------------------------------------------------
// twcc_ctrl
// Sequencer: bitmap clear after reset, label loading, slot scan with the
// bottom-up level climb, and hand-off of the result.
// ----------------------------------------------------------------------------
module twcc_ctrl
    import twcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.init_end) begin
                    o_cmd.addr_clr = 1'b1;
                    n_state        = S_LOAD;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_in_last) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_sts.in_lim) begin
                    n_state = S_LEAF;
                end else begin
                    // Slot beyond the tree: only stale bits to clear.
                    o_cmd.clr_wr = 1'b1;
                    if (i_sts.scan_end) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.addr_inc = 1'b1;
                    end
                end
            end
            S_LEAF: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.leaf_mode) begin
                    o_cmd.leaf_scan = 1'b1;
                    if (i_sts.scan_end) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.addr_inc = 1'b1;
                        n_state        = S_READ;
                    end
                end else begin
                    o_cmd.leaf_tree = 1'b1;
                    n_state         = S_CLIMB;
                end
            end
            S_CLIMB: begin
                o_cmd.climb = 1'b1;
                if (i_sts.climb_done) begin
                    if (i_sts.scan_end) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.addr_inc = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.addr_clr = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end
endmodule

### design/twcc_dpath.sv
// ----------------------------------------------------------------------------
// twcc_dpath
// Datapath: configuration registers, occupancy bitmap, slot address, level
// climb registers, count accumulators and the result register.
// ----------------------------------------------------------------------------
module twcc_dpath
    import twcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]     i_station_label,
    input  logic                  i_label_valid,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PROBE_W-1:0]    o_probe_count,
    output logic [COLL_W-1:0]     o_collision_count,
    output logic [SUCC_W-1:0]     o_success_count,
    output logic [IDLE_W-1:0]     o_idle_count
);
    logic [DEPTH_W-1:0] r_depth;
    logic               r_mode;
    logic [CNT_W-1:0]   r_addr;
    logic [CNT_W-1:0]   r_hwm, n_hwm;
    logic [LVL_W-1:0]   r_lvl;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_left [MAX_DEPTH];

    logic [PROBE_W-1:0] r_probe, n_probe;
    logic [COLL_W-1:0]  r_coll, n_coll;
    logic [SUCC_W-1:0]  r_succ, n_succ;
    logic [IDLE_W-1:0]  r_idle, n_idle;

    logic               r_out_valid;
    logic [PROBE_W-1:0] r_out_probe;
    logic [COLL_W-1:0]  r_out_coll;
    logic [SUCC_W-1:0]  r_out_succ;
    logic [IDLE_W-1:0]  r_out_idle;

    logic [LVL_W-1:0]   k;
    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   addr_nxt;
    logic               label_ok;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_wdata;
    logic               ram_rdata;
    logic               is_root;
    logic               addr_bit;
    logic [FILL_W-1:0]  left_fill;
    logic [FILL_W-1:0]  par_fill;
    t_inc               inc_a, inc_b;

    // Effective depth: zero acts as one, anything above the maximum as the maximum.
    always_comb begin
        if (r_depth == '0) begin
            k = LVL_W'(1);
        end else if (r_depth > DEPTH_W'(MAX_DEPTH)) begin
            k = LVL_W'(MAX_DEPTH);
        end else begin
            k = LVL_W'(r_depth);
        end
    end

    assign lim      = CNT_W'(1) << k;
    assign addr_nxt = r_addr + CNT_W'(1);
    assign label_ok = i_label_valid && ({1'b0, i_station_label} < lim);

    // Bitmap write port: a valid in-tree label sets its slot; init, scan and sweeps clear.
    assign ram_we    = (i_cmd.load_wr && label_ok) || i_cmd.clr_wr;
    assign ram_waddr = i_cmd.load_wr ? i_station_label : r_addr[ADDR_W-1:0];
    assign ram_wdata = i_cmd.load_wr;

    twcc_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign is_root   = (r_lvl == k);
    assign addr_bit  = is_root ? 1'b0 : r_addr[r_lvl[LIDX_W-1:0]];
    assign left_fill = is_root ? FILL_NONE : r_left[r_lvl[LIDX_W-1:0]];
    assign par_fill  = fill_add(left_fill, r_fill);

    assign o_sts.init_end   = (r_addr == CNT_W'(SLOTS - 1));
    assign o_sts.scan_end   = (addr_nxt >= lim) && (addr_nxt >= r_hwm);
    assign o_sts.in_lim     = (r_addr < lim);
    assign o_sts.climb_done = is_root || !addr_bit;
    assign o_sts.leaf_mode  = r_mode;
    assign o_sts.out_free   = !r_out_valid;

    // When a right child closes, the parent's fill is known. Both children are
    // probed exactly when the parent collided; leaf children are covered by
    // the pair rule of their parent.
    always_comb begin
        inc_a   = '0;
        inc_b   = '0;
        n_probe = r_probe;
        n_coll  = r_coll;
        n_succ  = r_succ;
        n_idle  = r_idle;
        if (i_cmd.climb) begin
            if (is_root) begin
                inc_a = node_inc(r_fill, r_lvl);
            end else if (addr_bit && (r_lvl != '0) && (par_fill == FILL_MANY)) begin
                inc_a = node_inc(left_fill, r_lvl);
                inc_b = node_inc(r_fill, r_lvl);
            end
        end else if (i_cmd.leaf_scan) begin
            inc_a.probe = 2'd1;
            inc_a.succ  = {1'b0, ram_rdata};
            inc_a.idle  = !ram_rdata;
        end
        n_probe = r_probe + PROBE_W'({1'b0, inc_a.probe} + {1'b0, inc_b.probe});
        n_coll  = r_coll + COLL_W'({1'b0, inc_a.coll} + {1'b0, inc_b.coll});
        n_succ  = r_succ + SUCC_W'({1'b0, inc_a.succ} + {1'b0, inc_b.succ});
        n_idle  = r_idle + IDLE_W'({1'b0, inc_a.idle} + {1'b0, inc_b.idle});
    end

    function automatic logic addr_hwm_gt();
        return ({1'b0, i_station_label} >= r_hwm);
    endfunction

    always_comb begin
        n_hwm = r_hwm;
        if (i_cmd.load_wr && label_ok && (addr_hwm_gt())) begin
            n_hwm = {1'b0, i_station_label} + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= DEPTH_RESET;
            r_mode      <= 1'b0;
            r_addr      <= '0;
            r_hwm       <= '0;
            r_probe     <= '0;
            r_coll      <= '0;
            r_succ      <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TREE_DEPTH: r_depth <= i_cfg_data[DEPTH_W-1:0];
                    CFG_SCAN_MODE:  r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.addr_clr) begin
                r_addr <= '0;
            end else if (i_cmd.addr_inc) begin
                r_addr <= addr_nxt;
            end

            if (i_cmd.out_load) begin
                r_hwm   <= '0;
                r_probe <= '0;
                r_coll  <= '0;
                r_succ  <= '0;
                r_idle  <= '0;
            end else begin
                r_hwm   <= n_hwm;
                r_probe <= n_probe;
                r_coll  <= n_coll;
                r_succ  <= n_succ;
                r_idle  <= n_idle;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Level climb registers and the left-sibling fill of each level.
    always_ff @(posedge i_clk) begin
        if (i_cmd.leaf_tree) begin
            r_lvl  <= '0;
            r_fill <= {1'b0, ram_rdata};
        end else if (i_cmd.climb && !is_root) begin
            if (addr_bit) begin
                r_lvl  <= r_lvl + LVL_W'(1);
                r_fill <= par_fill;
            end else begin
                r_left[r_lvl[LIDX_W-1:0]] <= r_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_probe <= r_probe;
            r_out_coll  <= r_coll;
            r_out_succ  <= r_succ;
            r_out_idle  <= r_idle;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_probe_count     = r_out_probe;
    assign o_collision_count = r_out_coll;
    assign o_success_count   = r_out_succ;
    assign o_idle_count      = r_out_idle;
endmodule

### verif/twcc_count_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twcc_count_checker
// Watches the configuration port and both channels of the collision counter,
// keeps its own occupancy bitmap and register copies, works out the counts of
// every resolved set and compares them with the results in arrival order.
// ----------------------------------------------------------------------------
module twcc_count_checker
    import twcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    twcc_label_if                 i_label,
    twcc_result_if                i_result,
    output int                    o_fail_count,
    output int                    o_awaited,
    output int                    o_sets_checked
);

    typedef struct packed {
        logic [PROBE_W-1:0] probe;
        logic [COLL_W-1:0]  coll;
        logic [SUCC_W-1:0]  succ;
        logic [IDLE_W-1:0]  idle;
    } set_counts_t;

    logic [SLOTS-1:0]   occupied;
    logic [DEPTH_W-1:0] depth_reg;
    logic               leaf_mode;
    set_counts_t        awaited_counts[$];

    function automatic int depth_in_use(input logic [DEPTH_W-1:0] d);
        if (d < 1) begin
            return 1;
        end
        if (d > MAX_DEPTH) begin
            return MAX_DEPTH;
        end
        return int'(d);
    endfunction

    // Occupied slots in [lo, lo + size), saturating at two.
    function automatic int node_fill(input int lo, input int size);
        int n;
        int i;
        n = 0;
        for (i = 0; i < size && n < 2; i++) begin
            if (occupied[ADDR_W'(lo + i)]) begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic set_counts_t walk_node(input int lo, input int k);
        set_counts_t c;
        set_counts_t lower;
        set_counts_t upper;
        int          n;
        c = '0;
        n = node_fill(lo, 1 << k);
        if (n == 0) begin
            c.probe = PROBE_W'(1);
            c.idle  = IDLE_W'(1);
        end else if (n == 1) begin
            c.probe = PROBE_W'(1);
            c.succ  = SUCC_W'(1);
        end else if (k <= 1) begin
            // A collided pair of leaves needs two more slots to resolve.
            c.probe = PROBE_W'(3);
            c.coll  = COLL_W'(1);
            c.succ  = SUCC_W'(2);
        end else begin
            lower   = walk_node(lo, k - 1);
            upper   = walk_node(lo + (1 << (k - 1)), k - 1);
            c.probe = PROBE_W'(1) + lower.probe + upper.probe;
            c.coll  = COLL_W'(1) + lower.coll + upper.coll;
            c.succ  = lower.succ + upper.succ;
            c.idle  = lower.idle + upper.idle;
        end
        return c;
    endfunction

    function automatic set_counts_t resolve_set();
        set_counts_t c;
        int          k;
        int          i;
        k = depth_in_use(depth_reg);
        if (!leaf_mode) begin
            return walk_node(0, k);
        end
        c = '0;
        for (i = 0; i < (1 << k); i++) begin
            c.probe = c.probe + 1'b1;
            if (occupied[ADDR_W'(i)]) begin
                c.succ = c.succ + 1'b1;
            end else begin
                c.idle = c.idle + 1'b1;
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] count check: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("set %0d %s is %0d, expected %0d",
                                      o_sets_checked, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        set_counts_t got;
        set_counts_t want;
        if (!i_rst_n) begin
            occupied = '0;
            depth_reg = DEPTH_RESET;
            leaf_mode = 1'b0;
            awaited_counts.delete();
            o_fail_count = 0;
            o_awaited = 0;
            o_sets_checked = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TREE_DEPTH) begin
                    depth_reg = i_cfg_data;
                end else if (i_cfg_idx == CFG_SCAN_MODE) begin
                    leaf_mode = i_cfg_data[0];
                end
            end
            if (i_label.valid && i_label.ready) begin
                if (i_label.label_valid &&
                    int'(i_label.station_label) < (1 << depth_in_use(depth_reg))) begin
                    occupied[i_label.station_label] = 1'b1;
                end
                if (i_label.last_label) begin
                    awaited_counts.push_back(resolve_set());
                    occupied = '0;
                end
            end
            if (i_result.valid && i_result.ready) begin
                got = {i_result.probe_count, i_result.collision_count,
                       i_result.success_count, i_result.idle_count};
                if (awaited_counts.size() == 0) begin
                    report_mismatch($sformatf("result transfer with no set pending: %h", got));
                end else begin
                    want = awaited_counts.pop_front();
                    compare_field("probe_count", 16'(got.probe), 16'(want.probe));
                    compare_field("collision_count", 16'(got.coll), 16'(want.coll));
                    compare_field("success_count", 16'(got.succ), 16'(want.succ));
                    compare_field("idle_count", 16'(got.idle), 16'(want.idle));
                    o_sets_checked++;
                end
            end
            o_awaited = awaited_counts.size();
        end
    end

endmodule

### verif/tree_walk_collision_counter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tree_walk_collision_counter_unit_tb
// Drives label sets through the collision counter under many depth and mode
// settings with random idling on both channels, a long result stall and full
// drains, while the count checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tree_walk_collision_counter_unit_tb;
    import twcc_pkg::*;

    localparam int   RANDOM_ITEMS     = 1150;
    localparam int   CALM_ITEMS       = 150;
    localparam int   LONG_HOLD_CYCLES = 400;
    localparam int   DRAIN_CYCLES     = 2 * SLOTS + 64;
    localparam int   TAIL_CYCLES      = 3 * SLOTS + 64;
    localparam int   PRESSURE_PHASE   = 2;
    localparam logic MODE_ROOT        = 1'b0;
    localparam logic MODE_LEAF        = 1'b1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    twcc_label_if  label_ch();
    twcc_result_if result_ch();

    int          fail_count;
    int          awaited;
    int          sets_checked;
    int          eff_depth;
    int          label_xfers;
    int          phase;
    bit          no_idle;
    int          hold_requests;
    logic [15:0] depth_codes_seen;
    logic [1:0]  modes_seen;

    tree_walk_collision_counter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_label    (label_ch),
        .o_result   (result_ch)
    );

    twcc_count_checker count_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_label        (label_ch),
        .i_result       (result_ch),
        .o_fail_count   (fail_count),
        .o_awaited      (awaited),
        .o_sets_checked (sets_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_label(input logic [9:0] lbl, input logic lv, input logic last);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            label_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        label_ch.valid         <= 1'b1;
        label_ch.station_label <= lbl;
        label_ch.label_valid   <= lv;
        label_ch.last_label    <= last;
        @(posedge i_clk);
        while (!label_ch.ready) @(posedge i_clk);
        label_xfers++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        label_ch.valid <= 1'b0;
        while (awaited != 0) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [DEPTH_W-1:0] depth, input logic mode);
        logic [CFG_DATA_W-2:0] pad;
        pad = (CFG_DATA_W-1)'($urandom);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TREE_DEPTH;
        i_cfg_data <= depth;
        @(negedge i_clk);
        // Upper data bits of the mode write are don't-care and get random values.
        i_cfg_idx  <= CFG_SCAN_MODE;
        i_cfg_data <= {pad, mode};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        eff_depth = (depth < 1) ? 1 : (depth > MAX_DEPTH) ? MAX_DEPTH : int'(depth);
        depth_codes_seen[depth] = 1'b1;
        modes_seen[mode] = 1'b1;
    endtask

    task automatic send_random_set(input int n);
        int         span;
        int         base;
        int         i;
        bit         clustered;
        bit         last;
        logic [9:0] lbl;
        span = 1 << eff_depth;
        clustered = ($urandom_range(0, 1) == 1);
        base = $urandom_range(0, span - 1);
        for (i = 0; i < n; i++) begin
            last = (i == n - 1);
            if ($urandom_range(0, 9) == 0 || (last && $urandom_range(0, 2) == 0)) begin
                // Noise: an empty marker, or a label beyond the tree that must be ignored.
                if (eff_depth == MAX_DEPTH || $urandom_range(0, 1) == 0) begin
                    send_label(10'($urandom), 1'b0, last);
                end else begin
                    send_label(10'($urandom_range(span, SLOTS - 1)), 1'b1, last);
                end
            end else begin
                // Clustered labels force collisions deep down the tree.
                if (clustered) begin
                    lbl = 10'((base + $urandom_range(0, 3)) & (span - 1));
                end else begin
                    lbl = 10'($urandom_range(0, span - 1));
                end
                send_label(lbl, 1'b1, last);
            end
        end
    endtask

    initial begin : result_sink
        int burst;
        int holds_served;
        holds_served = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 12);
                result_ch.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [DEPTH_W-1:0] depth;
        int                 n_sets;
        int                 s;
        bit                 big;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_TREE_DEPTH;
        i_cfg_data             = '0;
        label_ch.valid         = 1'b0;
        label_ch.station_label = '0;
        label_ch.label_valid   = 1'b0;
        label_ch.last_label    = 1'b0;
        eff_depth              = int'(DEPTH_RESET);
        hold_requests          = 0;
        depth_codes_seen       = '0;
        modes_seen             = '0;
        depth_codes_seen[DEPTH_RESET] = 1'b1;
        modes_seen[MODE_ROOT]  = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset: depth 3, root walk.
        send_label(10'd0, 1'b1, 1'b0);
        send_label(10'd7, 1'b1, 1'b1);
        send_label(10'($urandom), 1'b0, 1'b1);
        send_label(10'd5, 1'b1, 1'b0);
        send_label(10'd5, 1'b1, 1'b0);
        send_label(10'd5, 1'b1, 1'b1);
        send_label(10'd8, 1'b1, 1'b0);
        send_label(10'd1023, 1'b1, 1'b0);
        send_label(10'd2, 1'b1, 1'b0);
        send_label(10'($urandom), 1'b0, 1'b1);
        // Smallest tree: a pair of leaves that collide.
        set_config(4'd1, MODE_ROOT);
        send_label(10'd0, 1'b1, 1'b0);
        send_label(10'd1, 1'b1, 1'b1);
        // A depth code of zero behaves as depth one.
        set_config(4'd0, MODE_ROOT);
        send_label(10'd1, 1'b1, 1'b1);
        send_label(10'd2, 1'b1, 1'b0);
        send_label(10'd0, 1'b1, 1'b1);
        // A code above the maximum is clipped to the full tree, here with a leaf scan.
        set_config(4'd15, MODE_LEAF);
        send_label(10'd1023, 1'b1, 1'b0);
        send_label(10'd0, 1'b1, 1'b1);
        set_config(4'd10, MODE_ROOT);
        send_label(10'd512, 1'b1, 1'b0);
        send_label(10'd513, 1'b1, 1'b0);
        send_label(10'd1023, 1'b1, 1'b1);
        set_config(4'd2, MODE_LEAF);
        send_label(10'd3, 1'b1, 1'b0);
        send_label(10'($urandom), 1'b0, 1'b1);

        phase = 0;
        while (label_xfers < RANDOM_ITEMS) begin
            big = ($urandom_range(0, 5) == 0) && (phase != PRESSURE_PHASE);
            if (phase == PRESSURE_PHASE) begin
                depth = 4'd2;
            end else if (big) begin
                depth = 4'($urandom_range(6, 15));
            end else begin
                depth = 4'($urandom_range(0, 5));
            end
            set_config(depth, 1'($urandom_range(0, 1)));
            if (phase == PRESSURE_PHASE) begin
                // Hold off results so the output register fills and labels back up.
                hold_requests++;
                n_sets = 12;
            end else begin
                n_sets = big ? 2 : $urandom_range(4, 10);
            end
            for (s = 0; s < n_sets; s++) begin
                send_random_set(big ? $urandom_range(10, 40) : $urandom_range(1, 12));
                if ((phase == PRESSURE_PHASE && s == n_sets / 2) ||
                    (!big && $urandom_range(0, 5) == 0)) begin
                    wait_for_results();
                end
            end
            if (label_xfers >= RANDOM_ITEMS - CALM_ITEMS) begin
                no_idle = 1'b1;
            end
            phase++;
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Run covered %0d label transfers and %0d checked sets over %0d random phases.",
                 label_xfers, sets_checked, phase);
        $display("Depth codes used %b, scan modes used %b, with one long result stall.",
                 depth_codes_seen, modes_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("Timeout with %0d results outstanding.", awaited);
        $display("== FAIL ==");
        $finish;
    end

endmodule
